// ----- rtl/rpnh_pkg.sv -----
// Package for the ray / polygon nearest-hit block: item types, register
// indexes, reset values, controller states and datapath operation codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rpnh_pkg;

  // Fixed field widths
  localparam int COORD_BITS = 16;
  localparam int DIR_W      = 16;
  localparam int MD_W       = 20;
  localparam int OUT_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 3'd4;

  // Register reset values
  localparam logic signed [DIR_W-1:0] DIR_X_RST = 16'sd1;
  localparam logic [MD_W-1:0]         MD_RST    = 20'd1000000;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         polygon_end;
    logic                         scene_end;
  } in_item_t;

  typedef struct packed {
    logic                    hit;
    logic signed [OUT_W-1:0] hit_x;
    logic signed [OUT_W-1:0] hit_y;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_SETUP,
    ST_DEN_A,
    ST_DEN_B,
    ST_RN_A,
    ST_RN_B,
    ST_SN_A,
    ST_SN_B,
    ST_CHECK,
    ST_NUM_X,
    ST_DIV_X,
    ST_NUM_Y,
    ST_DIV_Y,
    ST_POINT,
    ST_DIST_A,
    ST_DIST_B,
    ST_LIMIT,
    ST_UPDATE,
    ST_FINISH,
    ST_EMIT
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_SETUP,
    OP_DEN_A,
    OP_DEN_B,
    OP_RN_A,
    OP_RN_B,
    OP_SN_A,
    OP_SN_B,
    OP_CHECK,
    OP_NUM_X,
    OP_DIV_X,
    OP_NUM_Y,
    OP_DIV_Y,
    OP_POINT,
    OP_DIST_A,
    OP_DIST_B,
    OP_LIMIT,
    OP_UPDATE,
    OP_FINISH,
    OP_EMIT
  } dp_op_t;

  // Controller to datapath
  typedef struct packed {
    dp_op_t op;
    logic   edge_sel;   // 0: previous -> current, 1: current -> first
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic poly_open;
    logic close;
    logic scene;
    logic edge_ok;
    logic div_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/rpnh_div.sv -----
// Restoring divider, one quotient bit per cycle, for the hit point offset.
// Needs num / den < 2^Q_W. Standalone, no package use.
`timescale 1ns / 1ps
`default_nettype none

module rpnh_div #(
  parameter int NUM_W = 59,
  parameter int DEN_W = 34,
  parameter int Q_W   = 25
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [Q_W-1:0]        quo
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [Q_W-1:0]   quo_r;

  logic [DEN_W:0]   sh;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;
  logic [Q_W-1:0]   quo_nxt;

  // One shift / subtract step
  always_comb begin
    sh      = {rem_r, quo_r[Q_W-1]};
    diff    = sh - {1'b0, den_r};
    ge      = (sh >= {1'b0, den_r});
    rem_nxt = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
    quo_nxt = {quo_r[Q_W-2:0], ge};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(Q_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[NUM_W-1:Q_W];
      quo_r <= num[Q_W-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

// ----- rtl/rpnh_ctrl.sv -----
// Controller: sequences item intake, the edge tests (previous to current and,
// on a close, current to first) and the result register handshake. Uses rpnh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpnh_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire rpnh_pkg::dp_status_t status,
  output rpnh_pkg::ctrl_cmd_t      cmd
);

  rpnh_pkg::ctrl_state_t state_r, state_nxt;
  logic edge_sel_r, edge_sel_nxt;
  logic out_valid_r, out_valid_nxt;
  logic can_emit;
  logic emit;

  assign can_emit = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt    = state_r;
    edge_sel_nxt = edge_sel_r;
    unique case (state_r)
      rpnh_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = rpnh_pkg::ST_START;
      end
      rpnh_pkg::ST_START: begin
        if (status.poly_open) begin
          state_nxt    = rpnh_pkg::ST_SETUP;
          edge_sel_nxt = 1'b0;
        end else if (status.close) begin
          state_nxt    = rpnh_pkg::ST_SETUP;
          edge_sel_nxt = 1'b1;
        end else begin
          state_nxt = rpnh_pkg::ST_FINISH;
        end
      end
      rpnh_pkg::ST_SETUP:  state_nxt = rpnh_pkg::ST_DEN_A;
      rpnh_pkg::ST_DEN_A:  state_nxt = rpnh_pkg::ST_DEN_B;
      rpnh_pkg::ST_DEN_B:  state_nxt = rpnh_pkg::ST_RN_A;
      rpnh_pkg::ST_RN_A:   state_nxt = rpnh_pkg::ST_RN_B;
      rpnh_pkg::ST_RN_B:   state_nxt = rpnh_pkg::ST_SN_A;
      rpnh_pkg::ST_SN_A:   state_nxt = rpnh_pkg::ST_SN_B;
      rpnh_pkg::ST_SN_B:   state_nxt = rpnh_pkg::ST_CHECK;
      rpnh_pkg::ST_CHECK: begin
        if (status.edge_ok) begin
          state_nxt = rpnh_pkg::ST_NUM_X;
        end else if (!edge_sel_r && status.close) begin
          state_nxt    = rpnh_pkg::ST_SETUP;
          edge_sel_nxt = 1'b1;
        end else begin
          state_nxt = rpnh_pkg::ST_FINISH;
        end
      end
      rpnh_pkg::ST_NUM_X:  state_nxt = rpnh_pkg::ST_DIV_X;
      rpnh_pkg::ST_DIV_X: begin
        if (status.div_done) state_nxt = rpnh_pkg::ST_NUM_Y;
      end
      rpnh_pkg::ST_NUM_Y:  state_nxt = rpnh_pkg::ST_DIV_Y;
      rpnh_pkg::ST_DIV_Y: begin
        if (status.div_done) state_nxt = rpnh_pkg::ST_POINT;
      end
      rpnh_pkg::ST_POINT:  state_nxt = rpnh_pkg::ST_DIST_A;
      rpnh_pkg::ST_DIST_A: state_nxt = rpnh_pkg::ST_DIST_B;
      rpnh_pkg::ST_DIST_B: state_nxt = rpnh_pkg::ST_LIMIT;
      rpnh_pkg::ST_LIMIT:  state_nxt = rpnh_pkg::ST_UPDATE;
      rpnh_pkg::ST_UPDATE: begin
        if (!edge_sel_r && status.close) begin
          state_nxt    = rpnh_pkg::ST_SETUP;
          edge_sel_nxt = 1'b1;
        end else begin
          state_nxt = rpnh_pkg::ST_FINISH;
        end
      end
      rpnh_pkg::ST_FINISH: begin
        state_nxt = status.scene ? rpnh_pkg::ST_EMIT : rpnh_pkg::ST_IDLE;
      end
      rpnh_pkg::ST_EMIT: begin
        if (can_emit) state_nxt = rpnh_pkg::ST_IDLE;
      end
      default: state_nxt = rpnh_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd.edge_sel = edge_sel_r;
    cmd.op       = rpnh_pkg::OP_NONE;
    emit         = 1'b0;
    unique case (state_r)
      rpnh_pkg::ST_IDLE:   cmd.op = in_valid ? rpnh_pkg::OP_LATCH : rpnh_pkg::OP_NONE;
      rpnh_pkg::ST_START:  cmd.op = rpnh_pkg::OP_NONE;
      rpnh_pkg::ST_SETUP:  cmd.op = rpnh_pkg::OP_SETUP;
      rpnh_pkg::ST_DEN_A:  cmd.op = rpnh_pkg::OP_DEN_A;
      rpnh_pkg::ST_DEN_B:  cmd.op = rpnh_pkg::OP_DEN_B;
      rpnh_pkg::ST_RN_A:   cmd.op = rpnh_pkg::OP_RN_A;
      rpnh_pkg::ST_RN_B:   cmd.op = rpnh_pkg::OP_RN_B;
      rpnh_pkg::ST_SN_A:   cmd.op = rpnh_pkg::OP_SN_A;
      rpnh_pkg::ST_SN_B:   cmd.op = rpnh_pkg::OP_SN_B;
      rpnh_pkg::ST_CHECK:  cmd.op = rpnh_pkg::OP_CHECK;
      rpnh_pkg::ST_NUM_X:  cmd.op = rpnh_pkg::OP_NUM_X;
      rpnh_pkg::ST_DIV_X:  cmd.op = rpnh_pkg::OP_DIV_X;
      rpnh_pkg::ST_NUM_Y:  cmd.op = rpnh_pkg::OP_NUM_Y;
      rpnh_pkg::ST_DIV_Y:  cmd.op = rpnh_pkg::OP_DIV_Y;
      rpnh_pkg::ST_POINT:  cmd.op = rpnh_pkg::OP_POINT;
      rpnh_pkg::ST_DIST_A: cmd.op = rpnh_pkg::OP_DIST_A;
      rpnh_pkg::ST_DIST_B: cmd.op = rpnh_pkg::OP_DIST_B;
      rpnh_pkg::ST_LIMIT:  cmd.op = rpnh_pkg::OP_LIMIT;
      rpnh_pkg::ST_UPDATE: cmd.op = rpnh_pkg::OP_UPDATE;
      rpnh_pkg::ST_FINISH: cmd.op = rpnh_pkg::OP_FINISH;
      rpnh_pkg::ST_EMIT: begin
        emit   = can_emit;
        cmd.op = can_emit ? rpnh_pkg::OP_EMIT : rpnh_pkg::OP_NONE;
      end
      default: cmd.op = rpnh_pkg::OP_NONE;
    endcase
  end

  // Result register valid flag
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpnh_pkg::ST_IDLE;
      edge_sel_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      edge_sel_r  <= edge_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == rpnh_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/rpnh_dp.sv -----
// Datapath: configuration registers, polygon vertex registers, cross-product
// edge test on one shared multiplier, hit point and nearest-hit tracking.
// Uses rpnh_pkg and rpnh_div.
`timescale 1ns / 1ps
`default_nettype none

module rpnh_dp #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [rpnh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rpnh_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire rpnh_pkg::in_item_t                  in_data,
  output rpnh_pkg::out_item_t                      out_data,
  input  wire rpnh_pkg::ctrl_cmd_t                 cmd,
  output rpnh_pkg::dp_status_t                     status
);

  localparam int CW     = rpnh_pkg::COORD_BITS;
  localparam int EW     = CW + 1;
  localparam int DEN_W  = rpnh_pkg::DIR_W + EW + 1;
  localparam int RN_W   = 2 * EW + 1;
  localparam int MA_W   = DEN_W + 1;
  localparam int QW     = CW + FRAC_BITS + 1;
  localparam int PXW    = QW + 1;
  localparam int MB_W   = PXW;
  localparam int PW     = MA_W + MB_W;
  localparam int NUM_W  = DEN_W + QW;
  localparam int DSQ_W  = 2 * PXW + 1;
  localparam int LIM_W  = 2 * rpnh_pkg::MD_W + 2 * FRAC_BITS;
  localparam int CMP_W  = (DSQ_W > LIM_W) ? DSQ_W : LIM_W;
  localparam int OUT_W  = rpnh_pkg::OUT_W;

  // Configuration
  logic signed [CW-1:0]                origin_x_r, origin_y_r;
  logic signed [rpnh_pkg::DIR_W-1:0]   dir_x_r, dir_y_r;
  logic [rpnh_pkg::MD_W-1:0]           md_r;

  // Polygon tracking
  logic signed [CW-1:0] cur_x_r, cur_y_r, first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic                 inside_r, close_r, scene_r;

  // Edge test
  logic signed [CW-1:0]    ax_r, ay_r;
  logic signed [EW-1:0]    ex_r, ey_r, wx_r, wy_r;
  logic signed [PW-1:0]    t_r;
  logic signed [DEN_W-1:0] den_r, sn_r;
  logic signed [RN_W-1:0]  rn_r;
  logic [DEN_W-1:0]        dabs_r, sabs_r;
  logic [QW-1:0]           qx_r, qy_r;
  logic signed [PXW-1:0]   px_r, py_r;
  logic [DSQ_W-1:0]        dsq_r;

  // Nearest hit
  logic                    have_r;
  logic [DSQ_W-1:0]        best_d_r;
  logic signed [PXW-1:0]   best_x_r, best_y_r;
  rpnh_pkg::out_item_t     out_r;

  // Combinational helpers
  logic signed [CW-1:0]    sel_ax, sel_ay, sel_bx, sel_by;
  logic signed [EW-1:0]    exabs, eyabs;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [PW-1:0]    mul_p;
  logic                    den_neg;
  logic [DEN_W-1:0]        dabs_w;
  logic signed [DEN_W-1:0] sn_n;
  logic signed [RN_W-1:0]  rn_n;
  logic                    edge_ok;
  logic signed [PXW-1:0]   dist_a, dist_b;
  logic [NUM_W-1:0]        num_w;
  logic                    div_start, div_done;
  logic [QW-1:0]           div_quo;
  logic [CMP_W-1:0]        limit_w, dsq_w, best_w;
  logic                    take_hit;

  // Edge endpoints
  always_comb begin
    if (cmd.edge_sel) begin
      sel_ax = cur_x_r;
      sel_ay = cur_y_r;
      sel_bx = first_x_r;
      sel_by = first_y_r;
    end else begin
      sel_ax = prev_x_r;
      sel_ay = prev_y_r;
      sel_bx = cur_x_r;
      sel_by = cur_y_r;
    end
  end

  assign exabs = ex_r[EW-1] ? -ex_r : ex_r;
  assign eyabs = ey_r[EW-1] ? -ey_r : ey_r;

  // Distance terms relative to the origin in fixed point
  assign dist_a = px_r - (PXW'(origin_x_r) <<< FRAC_BITS);
  assign dist_b = py_r - (PXW'(origin_y_r) <<< FRAC_BITS);

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      rpnh_pkg::OP_DEN_A: begin mul_a = MA_W'(dir_x_r); mul_b = MB_W'(ey_r); end
      rpnh_pkg::OP_DEN_B: begin mul_a = MA_W'(dir_y_r); mul_b = MB_W'(ex_r); end
      rpnh_pkg::OP_RN_A:  begin mul_a = MA_W'(wx_r);    mul_b = MB_W'(ey_r); end
      rpnh_pkg::OP_RN_B:  begin mul_a = MA_W'(wy_r);    mul_b = MB_W'(ex_r); end
      rpnh_pkg::OP_SN_A:  begin mul_a = MA_W'(wx_r);    mul_b = MB_W'(dir_y_r); end
      rpnh_pkg::OP_SN_B:  begin mul_a = MA_W'(wy_r);    mul_b = MB_W'(dir_x_r); end
      rpnh_pkg::OP_NUM_X: begin
        mul_a = $signed(MA_W'(sabs_r));
        mul_b = MB_W'(exabs);
      end
      rpnh_pkg::OP_NUM_Y: begin
        mul_a = $signed(MA_W'(sabs_r));
        mul_b = MB_W'(eyabs);
      end
      rpnh_pkg::OP_DIST_A: begin mul_a = MA_W'(dist_a); mul_b = dist_a; end
      rpnh_pkg::OP_DIST_B: begin mul_a = MA_W'(dist_b); mul_b = dist_b; end
      rpnh_pkg::OP_LIMIT: begin
        mul_a = $signed(MA_W'(md_r));
        mul_b = $signed(MB_W'(md_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Hit test on the signed cross products, sign-normalized on den
  always_comb begin
    den_neg = den_r[DEN_W-1];
    dabs_w  = den_neg ? -den_r : den_r;
    sn_n    = den_neg ? -sn_r : sn_r;
    rn_n    = den_neg ? -rn_r : rn_r;
    edge_ok = (den_r != '0) && !sn_n[DEN_W-1] && !rn_n[RN_W-1]
              && (sn_n[DEN_W-1:0] <= dabs_w);
  end

  // Offset numerator: sn * |e| * 2^F + den / 2, rounds to nearest
  assign num_w = (mul_p[NUM_W-1:0] << FRAC_BITS) + NUM_W'(dabs_r >> 1);
  assign div_start = (cmd.op == rpnh_pkg::OP_NUM_X) || (cmd.op == rpnh_pkg::OP_NUM_Y);

  rpnh_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (QW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_w),
    .den   (dabs_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Range and nearest compare
  always_comb begin
    limit_w  = CMP_W'(t_r[2*rpnh_pkg::MD_W-1:0]) << (2 * FRAC_BITS);
    dsq_w    = CMP_W'(dsq_r);
    best_w   = CMP_W'(best_d_r);
    take_hit = (dsq_w < limit_w) && (!have_r || (dsq_w < best_w));
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      dir_x_r    <= rpnh_pkg::DIR_X_RST;
      dir_y_r    <= '0;
      md_r       <= rpnh_pkg::MD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rpnh_pkg::CFG_ORIGIN_X: origin_x_r <= $signed(cfg_data[CW-1:0]);
        rpnh_pkg::CFG_ORIGIN_Y: origin_y_r <= $signed(cfg_data[CW-1:0]);
        rpnh_pkg::CFG_DIR_X:    dir_x_r    <= $signed(cfg_data[rpnh_pkg::DIR_W-1:0]);
        rpnh_pkg::CFG_DIR_Y:    dir_y_r    <= $signed(cfg_data[rpnh_pkg::DIR_W-1:0]);
        rpnh_pkg::CFG_MAX_DIST: md_r       <= cfg_data[rpnh_pkg::MD_W-1:0];
        default: ;
      endcase
    end
  end

  // Control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      have_r   <= 1'b0;
    end else begin
      if (cmd.op == rpnh_pkg::OP_FINISH) inside_r <= !close_r;
      if (cmd.op == rpnh_pkg::OP_UPDATE && take_hit) begin
        have_r <= 1'b1;
      end else if (cmd.op == rpnh_pkg::OP_EMIT) begin
        have_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rpnh_pkg::OP_LATCH: begin
        cur_x_r <= in_data.vertex_x;
        cur_y_r <= in_data.vertex_y;
        close_r <= in_data.polygon_end | in_data.scene_end;
        scene_r <= in_data.scene_end;
        if (!inside_r) begin
          first_x_r <= in_data.vertex_x;
          first_y_r <= in_data.vertex_y;
        end
      end
      rpnh_pkg::OP_SETUP: begin
        ax_r <= sel_ax;
        ay_r <= sel_ay;
        ex_r <= EW'(sel_bx) - EW'(sel_ax);
        ey_r <= EW'(sel_by) - EW'(sel_ay);
        wx_r <= EW'(sel_ax) - EW'(origin_x_r);
        wy_r <= EW'(sel_ay) - EW'(origin_y_r);
      end
      rpnh_pkg::OP_DEN_A, rpnh_pkg::OP_RN_A, rpnh_pkg::OP_SN_A,
      rpnh_pkg::OP_DIST_A, rpnh_pkg::OP_LIMIT: begin
        t_r <= mul_p;
      end
      rpnh_pkg::OP_DEN_B: den_r <= $signed(t_r[DEN_W-1:0] - mul_p[DEN_W-1:0]);
      rpnh_pkg::OP_RN_B:  rn_r  <= $signed(t_r[RN_W-1:0] - mul_p[RN_W-1:0]);
      rpnh_pkg::OP_SN_B:  sn_r  <= $signed(t_r[DEN_W-1:0] - mul_p[DEN_W-1:0]);
      rpnh_pkg::OP_CHECK: begin
        dabs_r <= dabs_w;
        sabs_r <= sn_n[DEN_W-1:0];
      end
      rpnh_pkg::OP_DIV_X: if (div_done) qx_r <= div_quo;
      rpnh_pkg::OP_DIV_Y: if (div_done) qy_r <= div_quo;
      rpnh_pkg::OP_POINT: begin
        px_r <= (PXW'(ax_r) <<< FRAC_BITS)
                + (ex_r[EW-1] ? -$signed({1'b0, qx_r}) : $signed({1'b0, qx_r}));
        py_r <= (PXW'(ay_r) <<< FRAC_BITS)
                + (ey_r[EW-1] ? -$signed({1'b0, qy_r}) : $signed({1'b0, qy_r}));
      end
      rpnh_pkg::OP_DIST_B: dsq_r <= t_r[DSQ_W-1:0] + mul_p[DSQ_W-1:0];
      rpnh_pkg::OP_UPDATE: begin
        if (take_hit) begin
          best_d_r <= dsq_r;
          best_x_r <= px_r;
          best_y_r <= py_r;
        end
      end
      rpnh_pkg::OP_FINISH: begin
        prev_x_r <= cur_x_r;
        prev_y_r <= cur_y_r;
      end
      rpnh_pkg::OP_EMIT: begin
        out_r.hit   <= have_r;
        out_r.hit_x <= have_r ? $signed(best_x_r[OUT_W-1:0]) : '0;
        out_r.hit_y <= have_r ? $signed(best_y_r[OUT_W-1:0]) : '0;
      end
      default: ;
    endcase
  end

  assign out_data         = out_r;
  assign status.poly_open = inside_r;
  assign status.close     = close_r;
  assign status.scene     = scene_r;
  assign status.edge_ok   = edge_ok;
  assign status.div_done  = div_done;

endmodule

`default_nettype wire

// ----- rtl/ray_polygon_nearest_hit.sv -----
// Top level of the ray / polygon nearest-hit block: controller plus datapath.
// Uses rpnh_pkg, rpnh_ctrl, rpnh_dp.
//
//   port group   direction  handshake              payload
//   in_*         input      in_valid / in_ready    rpnh_pkg::in_item_t
//   out_*        output     out_valid / out_ready  rpnh_pkg::out_item_t
//   cfg_*        input      cfg_we                 cfg_index, cfg_data
//
// Items are taken one at a time: in_ready is high only while idle. A tested
// edge that hits runs the bit-serial divider once per coordinate, on a quotient
// of Q = 17 + FRAC_BITS bits (25 by default). A scene end loads the result
// register, which waits for a free slot if the previous result has not been
// taken. Reset is synchronous and restores the register defaults; no clearing
// pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module ray_polygon_nearest_hit #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire rpnh_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output rpnh_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [rpnh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rpnh_pkg::CFG_DATA_W-1:0] cfg_data
);

  rpnh_pkg::ctrl_cmd_t  cmd;
  rpnh_pkg::dp_status_t status;

  rpnh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rpnh_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire
